[hdl/nsrp_pkg.sv]
// ----------------------------------------------------------------------------
// nsrp_pkg
// Shared types, codes and reset contents for the nibble-serial port unit.
// ----------------------------------------------------------------------------
package nsrp_pkg;

  localparam int unsigned PORT_COUNT  = 16;
  localparam int unsigned STORE_DEPTH = 16;

  localparam logic [3:0] SERIAL_OFFSET = 4'hA;
  localparam logic [3:0] BANK_RD_FIRST = 4'h4;
  localparam logic [3:0] BANK_RD_LAST  = 4'h7;

  localparam logic [7:0] VIDEO_CODE_DEFAULT = 8'h10;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  // three-phase serial sequence, the fourth code is never entered
  typedef enum logic [1:0] {
    PH_INDEX = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [7:0] data;
  } win_req_t;

  function automatic logic [7:0] store_default(input logic [3:0] idx,
                                               input logic [7:0] video);
    logic [7:0] val;
    case (idx) inside
      4'h3, 4'h4, 4'hF: val = 8'h01;
      4'h5:             val = 8'h88;
      4'hB, 4'hD:       val = video;
      default:          val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[hdl/nibble_serial_rtc_port_unit.sv]
// ----------------------------------------------------------------------------
// nibble_serial_rtc_port_unit
// Sixteen-port I/O device: general register bank plus a nibble-serial
// window at offset 0xA onto the clock/NVRAM store.
// ----------------------------------------------------------------------------
// an accepted transaction's result is registered onto rsp in the next cycle
// throughput: one transaction per cycle, set by the single result register;
// no transaction is taken while a waiting result is held by rsp_stall
// reset: bank cleared, store loaded with its defaults,
//   serial sequence back at the index phase
module nibble_serial_rtc_port_unit #(
  parameter logic [7:0] VIDEO_CODE = nsrp_pkg::VIDEO_CODE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       opcode,
  input  logic [3:0] port_offset,
  input  logic [7:0] write_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);
  import nsrp_pkg::*;

  logic       accept;
  logic       is_write;
  logic       is_serial;
  logic       in_bank_rd;
  logic [7:0] bank [PORT_COUNT];
  logic [7:0] result;
  logic [3:0] rd_nibble;
  win_req_t   win_req;

  assign req_stall  = rsp_valid && rsp_stall;
  assign accept     = req_valid && !req_stall;
  assign is_write   = (opcode == OP_WRITE);
  assign is_serial  = (port_offset == SERIAL_OFFSET);
  assign in_bank_rd = (port_offset >= BANK_RD_FIRST) && (port_offset <= BANK_RD_LAST);

  assign win_req.rd   = accept && !is_write && is_serial;
  assign win_req.wr   = accept && is_write && is_serial;
  assign win_req.data = write_data;

  nsrp_window #(
    .VIDEO_CODE(VIDEO_CODE)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .req      (win_req),
    .rd_nibble(rd_nibble)
  );

  always_comb begin
    result = 8'h00;
    if (!is_write) begin
      if (in_bank_rd) result = bank[port_offset];
      else if (is_serial) result = {4'h0, rd_nibble};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        bank[i] <= 8'h00;
      end
    end else begin
      if (accept) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      if (accept && is_write) bank[port_offset] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) read_data <= result;
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted transaction produced no result");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && is_write) |=> read_data == 8'h00)
    else $error("write transaction returned non-zero data");

  // reads outside the bank range and the serial window return zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_write && !is_serial && !in_bank_rd) |=> read_data == 8'h00)
    else $error("unmapped read returned non-zero data");

  // serial reads only ever carry a nibble
  a_serial_nibble: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_write && is_serial) |=> read_data[7:4] == 4'h0)
    else $error("serial read returned bits above the nibble");

endmodule

[hdl/nsrp_window.sv]
// ----------------------------------------------------------------------------
// nsrp_window
// Nibble-serial window onto the sixteen-byte clock/NVRAM store: index
// (written only), high nibble, low nibble sequence shared by reads and writes.
// ----------------------------------------------------------------------------
module nsrp_window #(
  parameter logic [7:0] VIDEO_CODE = nsrp_pkg::VIDEO_CODE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  nsrp_pkg::win_req_t req,
  output logic [3:0]         rd_nibble
);
  import nsrp_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] index;
  logic [7:0] store [STORE_DEPTH];
  logic [7:0] entry;
  logic       load_index;
  logic       wr_high;
  logic       wr_low;

  assign entry = store[index];

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_INDEX: begin
        if (req.wr) phase_next = PH_HIGH;
      end
      PH_HIGH: begin
        if (req.rd || req.wr) phase_next = PH_LOW;
      end
      PH_LOW: begin
        if (req.rd || req.wr) phase_next = PH_INDEX;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    rd_nibble  = 4'h0;
    load_index = 1'b0;
    wr_high    = 1'b0;
    wr_low     = 1'b0;
    unique case (phase)
      PH_INDEX: begin
        load_index = req.wr;
      end
      PH_HIGH: begin
        if (req.rd) rd_nibble = entry[7:4];
        wr_high = req.wr;
      end
      PH_LOW: begin
        if (req.rd) rd_nibble = entry[3:0];
        wr_low = req.wr;
      end
      default: begin
        rd_nibble = 4'h0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_INDEX;
      index <= 4'h0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= store_default(4'(i), VIDEO_CODE);
      end
    end else begin
      phase <= phase_next;
      if (load_index) index <= req.data[3:0];
      if (wr_high) store[index][7:4] <= req.data[3:0];
      if (wr_low) store[index][3:0] <= req.data[3:0];
    end
  end

  // the unused phase code must never be entered
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase == PH_INDEX || phase == PH_HIGH || phase == PH_LOW)
    else $error("serial phase left the three-phase sequence");

  // an index load always moves on to the high nibble
  a_index_then_high: assert property (@(posedge clk) disable iff (rst)
    load_index |=> phase == PH_HIGH)
    else $error("index write did not advance to high nibble");

  // a nibble read and a nibble write never come together
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.rd && req.wr))
    else $error("serial read and write in the same transaction");

endmodule

[tb/sv/nibble_serial_rtc_port_unit_tb.sv]
// ----------------------------------------------------------------------------
// nibble_serial_rtc_port_unit_tb
// Self-checking bench for the sixteen-port unit: directed bank and serial
// window accesses, a long result hold-off, then random traffic under changing
// idle rates. Every read byte is checked in order against a mirror of the
// bank, the clock store and the serial sequence.
// ----------------------------------------------------------------------------
module nibble_serial_rtc_port_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsrp_pkg::*;

  localparam logic [7:0] VIDEO = VIDEO_CODE_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       opcode = OP_READ;
  logic [3:0] port_offset = '0;
  logic [7:0] write_data = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] read_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;

  logic [7:0] mirror_bank [PORT_COUNT];
  logic [7:0] mirror_store [STORE_DEPTH];
  phase_t     mirror_phase;
  logic [3:0] mirror_index;
  logic [7:0] pending_read_data [$];

  nibble_serial_rtc_port_unit #(.VIDEO_CODE(VIDEO)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .port_offset(port_offset),
    .write_data(write_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_data(read_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // applies one access to the mirror and returns the byte it reads back
  function automatic logic [7:0] predict_read_data(opcode_t op, logic [3:0] off,
                                                   logic [7:0] data);
    logic [7:0] result;
    logic [7:0] entry;
    result = 8'h00;
    entry = mirror_store[mirror_index];
    if (op == OP_WRITE) begin
      mirror_bank[off] = data;
      if (off == SERIAL_OFFSET) begin
        case (mirror_phase)
          PH_INDEX: begin
            mirror_index = data[3:0];
            mirror_phase = PH_HIGH;
          end
          PH_HIGH: begin
            mirror_store[mirror_index] = {data[3:0], entry[3:0]};
            mirror_phase = PH_LOW;
          end
          PH_LOW: begin
            mirror_store[mirror_index] = {entry[7:4], data[3:0]};
            mirror_phase = PH_INDEX;
          end
          default: ;
        endcase
      end
    end else if (off >= BANK_RD_FIRST && off <= BANK_RD_LAST) begin
      result = mirror_bank[off];
    end else if (off == SERIAL_OFFSET) begin
      case (mirror_phase)
        PH_HIGH: begin
          result = {4'h0, entry[7:4]};
          mirror_phase = PH_LOW;
        end
        PH_LOW: begin
          result = {4'h0, entry[3:0]};
          mirror_phase = PH_INDEX;
        end
        default: ;
      endcase
    end
    return result;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < 50) begin
      $display("mismatch: %s, got %02h, want %02h at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  // request side: every accepted transaction goes through the mirror
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      pending_read_data.push_back(predict_read_data(opcode_t'(opcode), port_offset,
                                                    write_data));
    end
  end

  // result side: compare against the oldest outstanding byte
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_read_data.size() == 0) begin
        report_mismatch("result with nothing outstanding", read_data, 8'h00);
      end else begin
        if (read_data !== pending_read_data[0]) begin
          report_mismatch("read_data", read_data, pending_read_data[0]);
        end
        void'(pending_read_data.pop_front());
      end
    end
  end

  // receiver: a hold-off counts down here, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        rsp_stall <= 1'b1;
        hold_cycles--;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_access(opcode_t op, logic [3:0] off, logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    opcode      <= op;
    port_offset <= off;
    write_data  <= data;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_read_data.size() != 0) @(posedge clk);
  endtask

  task automatic test_bank_window();
    send_access(OP_READ, 4'h5, 8'hFF);
    send_access(OP_WRITE, 4'h5, 8'hFF);
    send_access(OP_READ, 4'h5, 8'h00);
    send_access(OP_WRITE, 4'h7, 8'h00);
    send_access(OP_READ, 4'h7, 8'hFF);
    send_access(OP_WRITE, 4'hF, 8'hA5);
    // bank holds it, but only offsets 4 to 7 read back
    send_access(OP_READ, 4'hF, 8'h00);
    send_access(OP_READ, 4'h0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_serial_reads();
    // read in the index phase gives zero and does not advance
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    // upper bits of the index byte are dropped
    send_access(OP_WRITE, SERIAL_OFFSET, 8'hF5);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    // video code entry
    send_access(OP_WRITE, SERIAL_OFFSET, 8'h0D);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    wait_for_results();
  endtask

  task automatic test_serial_writes();
    send_access(OP_WRITE, SERIAL_OFFSET, 8'h0B);
    send_access(OP_WRITE, SERIAL_OFFSET, 8'hF3);
    send_access(OP_WRITE, SERIAL_OFFSET, 8'hFC);
    send_access(OP_WRITE, SERIAL_OFFSET, 8'h0B);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    // read of the high nibble, then a write of the low one
    send_access(OP_WRITE, SERIAL_OFFSET, 8'hE0);
    send_access(OP_READ, SERIAL_OFFSET, 8'h00);
    send_access(OP_WRITE, SERIAL_OFFSET, 8'h07);
    wait_for_results();
  endtask

  // result held off for a long stretch while the sender keeps offering
  task automatic test_stall_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 40;
    repeat (12) begin
      send_access(opcode_t'($urandom_range(0, 1)), 4'($urandom_range(4, 10)),
                  8'($urandom_range(0, 255)));
    end
    wait_for_results();
  endtask

  task automatic random_phase(int unsigned s_pct, int unsigned r_pct);
    int unsigned stop_at;
    int unsigned pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = sent_count + ITEMS_PER_PHASE;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // complete serial sequence with random content
        send_access(OP_WRITE, SERIAL_OFFSET, 8'($urandom_range(0, 255)));
        repeat (2) begin
          send_access(opcode_t'($urandom_range(0, 1)), SERIAL_OFFSET,
                      8'($urandom_range(0, 255)));
        end
      end else if (pick < 62) begin
        // broken sequence, phase left mid-way
        send_access(OP_WRITE, SERIAL_OFFSET, 8'($urandom_range(0, 255)));
        send_access(opcode_t'($urandom_range(0, 1)), SERIAL_OFFSET,
                    8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_access(opcode_t'($urandom_range(0, 1)), 4'($urandom_range(4, 7)),
                    8'($urandom_range(0, 255)));
      end else begin
        send_access(opcode_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
      end
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    random_phase(8, 87);
    random_phase(87, 8);
    random_phase(0, 0);
  endtask

  initial begin
    foreach (mirror_bank[i]) mirror_bank[i] = 8'h00;
    foreach (mirror_store[i]) mirror_store[i] = 8'h00;
    mirror_store[4'h3] = 8'h01;
    mirror_store[4'h4] = 8'h01;
    mirror_store[4'hF] = 8'h01;
    mirror_store[4'h5] = 8'h88;
    mirror_store[4'hB] = VIDEO;
    mirror_store[4'hD] = VIDEO;
    mirror_phase = PH_INDEX;
    mirror_index = 4'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_bank_window();
    test_serial_reads();
    test_serial_writes();
    test_stall_fill();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
